// File: design/scd_pkg.sv
// scd_pkg: shared types and codes for the sketch command stream decoder
// used by the decoder top level and its port checker; no dependencies
`default_nettype none

package scd_pkg;

    // bits 7:6 of a header byte
    typedef enum logic [1:0] {
        SHORT_MOVE_X   = 2'd0,
        SHORT_MOVE_Y   = 2'd1,
        SHORT_PAUSE    = 2'd2,
        SHORT_EXTENDED = 2'd3
    } t_short_code;

    // extended-form opcodes, bits 3:0 of an extended header
    typedef enum logic [3:0] {
        OP_MOVE_X     = 4'd0,
        OP_MOVE_Y     = 4'd1,
        OP_PAUSE      = 4'd2,
        OP_TOGGLE_PEN = 4'd3,
        OP_CLEAR      = 4'd4,
        OP_WAIT_KEY   = 4'd5,
        OP_SET_COLOUR = 4'd6
    } t_ext_op;

    // extended operand length codes, bits 5:4
    localparam logic [1:0] LEN_NONE  = 2'd0;
    localparam logic [1:0] LEN_FOUR  = 2'd3;

    // kind of an emitted draw command
    typedef enum logic [2:0] {
        KIND_LINE        = 3'd0,
        KIND_COLOUR_LINE = 3'd1,
        KIND_PAUSE       = 3'd2,
        KIND_CLEAR       = 3'd3,
        KIND_WAIT_KEY    = 3'd4
    } t_cmd_kind;

    localparam int unsigned FIELD_W   = 32;
    localparam int unsigned OUT_DATA_W = 5 * FIELD_W;
    localparam int unsigned KIND_W    = 3;
    localparam logic [FIELD_W-1:0] NO_COLOUR = '1;

endpackage

`default_nettype wire

// File: design/sketch_command_stream_decoder.sv
// sketch_command_stream_decoder: byte-stream decoder for vector drawing commands
// depends on scd_pkg for opcodes, command kinds and field widths
//
// usage
//   s_axis carries one command-stream byte per item in tdata[7:0]
//   m_axis carries one draw command per item: tuser holds the command kind,
//   tdata holds from_x, from_y, to_x, to_y, amount (32 bits each, low first)
//   one byte is taken per cycle while the output is not stalled; a byte passes
//   an input register, is decoded against the pen state and lands in the output
//   register, from which its result shows on m_axis
//   short bytes and operand bytes take this same path; most bytes give no
//   result and simply drop out of the pipe
//   when the receiver stalls, the output register holds its command and the
//   input register fills; s_axis_tready then falls until the output drains
//   reset (synchronous, active low) clears both pipe stages, puts the pen at
//   the origin and up, sets no colour and drops any half-gathered operand
//   coordinates wrap modulo 2^COORD_WIDTH and are shown as their low 32 bits,
//   zero-extended when COORD_WIDTH is narrower
`default_nettype none

module sketch_command_stream_decoder
    import scd_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // in_byte[7:0]
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // from_x, from_y, to_x, to_y, amount
    output logic [KIND_W-1:0]          m_axis_tuser    // cmd_kind
);

    // input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // drawing state
    logic [COORD_WIDTH-1:0] r_pos_x, r_pos_y, r_last_x, r_last_y;
    logic [COORD_WIDTH-1:0] n_pos_x, n_pos_y, n_last_x, n_last_y;
    logic                   r_pen, n_pen;
    logic [FIELD_W-1:0]     r_colour, n_colour;
    logic [2:0]             r_pend, n_pend;
    logic [3:0]             r_op, n_op;
    logic [FIELD_W-1:0]     r_acc, n_acc;
    logic                   r_first, n_first;

    // output stage
    logic               r_out_valid;
    t_cmd_kind          r_out_kind;
    logic [FIELD_W-1:0] r_out_fx, r_out_fy, r_out_tx, r_out_ty, r_out_amt;

    logic               w_adv;
    logic               w_res_valid;
    t_cmd_kind          w_res_kind;
    logic [FIELD_W-1:0] w_res_fx, w_res_fy, w_res_tx, w_res_ty, w_res_amt;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_comb begin
        logic [7:0]             b;
        logic [FIELD_W-1:0]     base;
        logic                   ex_valid;
        logic [3:0]             ex_op;
        logic [FIELD_W-1:0]     ex_operand;
        logic [COORD_WIDTH-1:0] ext;
        logic [COORD_WIDTH-1:0] new_y;

        b          = r_in_byte;
        n_pos_x    = r_pos_x;
        n_pos_y    = r_pos_y;
        n_last_x   = r_last_x;
        n_last_y   = r_last_y;
        n_pen      = r_pen;
        n_colour   = r_colour;
        n_pend     = r_pend;
        n_op       = r_op;
        n_acc      = r_acc;
        n_first    = r_first;
        ex_valid   = 1'b0;
        ex_op      = OP_MOVE_X;
        ex_operand = '0;
        base       = '0;

        if (r_pend != 3'd0) begin
            // operand byte, big-endian, sign taken from the first one
            base    = r_first ? {FIELD_W{b[7]}} : r_acc;
            n_acc   = {base[FIELD_W-9:0], b};
            n_first = 1'b0;
            n_pend  = r_pend - 3'd1;
            if (r_pend == 3'd1) begin
                ex_valid   = 1'b1;
                ex_op      = r_op;
                ex_operand = n_acc;
            end
        end else begin
            unique case (t_short_code'(b[7:6]))
                SHORT_MOVE_X: begin
                    ex_valid   = 1'b1;
                    ex_op      = OP_MOVE_X;
                    ex_operand = FIELD_W'($signed(b[5:0]));
                end
                SHORT_MOVE_Y: begin
                    ex_valid   = 1'b1;
                    ex_op      = OP_MOVE_Y;
                    ex_operand = FIELD_W'($signed(b[5:0]));
                end
                SHORT_PAUSE: begin
                    ex_valid   = 1'b1;
                    ex_op      = OP_PAUSE;
                    ex_operand = FIELD_W'(b[5:0]);
                end
                SHORT_EXTENDED: begin
                    n_op  = b[3:0];
                    n_acc = '0;
                    if (b[5:4] == LEN_NONE) begin
                        ex_valid = 1'b1;
                        ex_op    = b[3:0];
                    end else begin
                        n_pend  = (b[5:4] == LEN_FOUR) ? 3'd4 : {1'b0, b[5:4]};
                        n_first = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        ext   = COORD_WIDTH'($signed(ex_operand));
        new_y = r_pos_y + ext;

        w_res_valid = 1'b0;
        w_res_kind  = KIND_LINE;
        w_res_fx    = '0;
        w_res_fy    = '0;
        w_res_tx    = '0;
        w_res_ty    = '0;
        w_res_amt   = '0;

        if (ex_valid) begin
            unique case (t_ext_op'(ex_op))
                OP_MOVE_X: begin
                    n_last_x = r_pos_x;
                    n_pos_x  = r_pos_x + ext;
                end
                OP_MOVE_Y: begin
                    n_last_y = r_pos_y;
                    n_pos_y  = new_y;
                    if (r_pen) begin
                        w_res_valid = 1'b1;
                        w_res_fx    = FIELD_W'(r_last_x);
                        w_res_fy    = FIELD_W'(r_pos_y);
                        w_res_tx    = FIELD_W'(r_pos_x);
                        w_res_ty    = FIELD_W'(new_y);
                        if (r_colour == NO_COLOUR) begin
                            w_res_kind = KIND_LINE;
                        end else begin
                            w_res_kind = KIND_COLOUR_LINE;
                            w_res_amt  = r_colour;
                        end
                        n_last_x = r_pos_x;
                        n_last_y = new_y;
                    end
                end
                OP_PAUSE: begin
                    w_res_valid = 1'b1;
                    w_res_kind  = KIND_PAUSE;
                    w_res_amt   = ex_operand;
                    n_last_x    = r_pos_x;
                    n_last_y    = r_pos_y;
                end
                OP_TOGGLE_PEN: begin
                    n_pen    = !r_pen;
                    n_last_x = r_pos_x;
                    n_last_y = r_pos_y;
                end
                OP_CLEAR: begin
                    w_res_valid = 1'b1;
                    w_res_kind  = KIND_CLEAR;
                end
                OP_WAIT_KEY: begin
                    w_res_valid = 1'b1;
                    w_res_kind  = KIND_WAIT_KEY;
                end
                OP_SET_COLOUR: begin
                    n_colour = ex_operand;
                end
                default: ;  // unused opcodes only consume their operand
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_pen       <= 1'b0;
            r_colour    <= NO_COLOUR;
            r_pend      <= 3'd0;
            r_op        <= 4'd0;
            r_acc       <= '0;
            r_first     <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_pos_x     <= n_pos_x;
                r_pos_y     <= n_pos_y;
                r_last_x    <= n_last_x;
                r_last_y    <= n_last_y;
                r_pen       <= n_pen;
                r_colour    <= n_colour;
                r_pend      <= n_pend;
                r_op        <= n_op;
                r_acc       <= n_acc;
                r_first     <= n_first;
                r_out_valid <= w_res_valid;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (w_adv) begin
            r_out_kind <= w_res_kind;
            r_out_fx   <= w_res_fx;
            r_out_fy   <= w_res_fy;
            r_out_tx   <= w_res_tx;
            r_out_ty   <= w_res_ty;
            r_out_amt  <= w_res_amt;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {r_out_amt, r_out_ty, r_out_tx, r_out_fy, r_out_fx};

endmodule

`default_nettype wire

// File: design/scd_checker.sv
// scd_checker: port-level checks for the sketch command stream decoder
// depends on scd_pkg; bound to the top level at the end of this file
`default_nettype none

module scd_checker
    import scd_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [KIND_W-1:0]     m_axis_tuser
);

    // output pipe is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown right after reset");

    // a stalled item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed or dropped");

    // only lines carry coordinates
    a_no_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_LINE && m_axis_tuser != KIND_COLOUR_LINE
            |-> m_axis_tdata[4*FIELD_W-1:0] == '0)
        else $error("coordinates on a non-line command");

    // a plain line carries no colour
    a_plain_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_LINE
            |-> m_axis_tdata[OUT_DATA_W-1:4*FIELD_W] == '0)
        else $error("plain line with nonzero amount");

    // wait-for-key and clear carry no amount
    a_bare_cmds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_CLEAR || m_axis_tuser == KIND_WAIT_KEY)
            |-> m_axis_tdata[OUT_DATA_W-1:4*FIELD_W] == '0)
        else $error("clear or wait with nonzero amount");

endmodule

bind sketch_command_stream_decoder scd_checker u_scd_checker (.*);

`default_nettype wire
